@@ hw/rtl/ffha_pkg.sv @@
// Shared types and constants of the first-fit heap allocator.
// Used by ffha_ctrl, ffha_dpath and first_fit_heap_allocator_unit; no dependencies.
`default_nettype none
package ffha_pkg;

    // granule geometry
    localparam int GRANULE_BYTES = 32;
    localparam int GRANULE_SHIFT = 5;
    localparam int NEED_W        = 16;
    localparam int CFG_W         = 13;
    localparam int HANDLE_W      = 17;

    // request modes
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_FTAG  = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    // datapath operations
    localparam logic [4:0] OP_NOP    = 5'd0;
    localparam logic [4:0] OP_LATCH  = 5'd1;
    localparam logic [4:0] OP_CLR    = 5'd2;
    localparam logic [4:0] OP_RD_G   = 5'd3;
    localparam logic [4:0] OP_ADV    = 5'd4;
    localparam logic [4:0] OP_LOAD   = 5'd5;
    localparam logic [4:0] OP_SPLIT  = 5'd6;
    localparam logic [4:0] OP_AWG    = 5'd7;
    localparam logic [4:0] OP_LRD    = 5'd8;
    localparam logic [4:0] OP_LWR    = 5'd9;
    localparam logic [4:0] OP_DRD    = 5'd10;
    localparam logic [4:0] OP_DBAD   = 5'd11;
    localparam logic [4:0] OP_QUERY  = 5'd12;
    localparam logic [4:0] OP_FAIL   = 5'd13;
    localparam logic [4:0] OP_RSTART = 5'd14;
    localparam logic [4:0] OP_BMERGE = 5'd15;
    localparam logic [4:0] OP_RWG    = 5'd16;
    localparam logic [4:0] OP_FRD    = 5'd17;
    localparam logic [4:0] OP_FMERGE = 5'd18;
    localparam logic [4:0] OP_TADV   = 5'd19;
    localparam logic [4:0] OP_DONE   = 5'd20;

    typedef struct packed {
        logic [1:0]  mode;
        logic [19:0] request_bytes;
        logic [31:0] tag;
        logic [16:0] handle;
    } t_req;

    typedef struct packed {
        logic [16:0] new_handle;
        logic [1:0]  status;
        logic [16:0] payload_bytes;
        logic [17:0] used_bytes;
        logic [12:0] used_blocks;
    } t_res;

    typedef struct packed {
        logic [4:0] op;
    } t_cmd;

    typedef struct packed {
        logic       rd_len_zero;
        logic       fit;
        logic       tag_hit;
        logic       adv_end;
        logic       can_split;
        logic       back_ok;
        logic       rd_alloc;
        logic       fwd_in;
        logic       clr_done;
        logic       dec_null;
        logic       dec_ok;
        logic       rd_owned;
        logic [1:0] mode;
    } t_stat;

endpackage
`default_nettype wire

@@ hw/rtl/first_fit_heap_allocator_unit.sv @@
// Top level of the first-fit heap allocator with coalescing.
// Depends on ffha_pkg, ffha_ctrl and ffha_dpath.
//
//  channel   signals                         direction  transfer
//  request   start, busy, i_req              in         start & !busy
//  result    o_done, o_res                   out        o_done, one cycle
//  config    i_cfg_we, i_cfg_wdata           in         i_cfg_we
//
// After reset and after each heap size write, a clearing pass over all HEAP_GRANULES
// header words runs with busy high. Allocation walks the headers in order up to the
// first free block that fits and splits it when enough is left. Free and query decode
// the handle and read its header; free and free-by-tag (a walk over all headers) merge
// released blocks with free neighbours. The header memory serves one read per cycle.
// Each result is shown for one cycle on o_done; the receiver cannot stall.
`default_nettype none
module first_fit_heap_allocator_unit #(
    parameter int HEAP_GRANULES = 4096
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    output logic             busy,
    input  ffha_pkg::t_req   i_req,
    output logic             o_done,
    output ffha_pkg::t_res   o_res,
    input  wire              i_cfg_we,
    input  wire [ffha_pkg::CFG_W-1:0] i_cfg_wdata
);
    ffha_pkg::t_cmd  cmd;
    ffha_pkg::t_stat stat;

    ffha_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cfg_we (i_cfg_we),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    ffha_dpath #(
        .HEAP_GRANULES (HEAP_GRANULES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .o_res       (o_res),
        .o_done      (o_done)
    );

    // a result only follows work
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result word without preceding work");

    // an accepted word keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted word did not start work");

    // a failed allocation returns a null handle
    a_oom_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == ffha_pkg::ST_OOM) |-> (o_res.new_handle == '0))
        else $error("out of memory with non-null handle");

    // payload size only comes from a successful query
    a_pay_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.payload_bytes != '0) |->
            (o_res.status == ffha_pkg::ST_OK && o_res.new_handle == '0))
        else $error("payload size with other result fields");

endmodule
`default_nettype wire

@@ hw/rtl/ffha_dpath.sv @@
// Datapath of the heap allocator: header and tag memories, walk registers, totals.
// Depends on ffha_pkg; driven by ffha_ctrl through t_cmd.
`default_nettype none
module ffha_dpath #(
    parameter int HEAP_GRANULES = 4096
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  ffha_pkg::t_cmd   i_cmd,
    output ffha_pkg::t_stat  o_stat,
    input  wire              i_cfg_we,
    input  wire [ffha_pkg::CFG_W-1:0] i_cfg_wdata,
    input  ffha_pkg::t_req   i_req,
    output ffha_pkg::t_res   o_res,
    output logic             o_done
);
    localparam int AW = (HEAP_GRANULES > 1) ? $clog2(HEAP_GRANULES) : 1;
    localparam int LW = $clog2(HEAP_GRANULES + 1);
    localparam int QW = ffha_pkg::HANDLE_W - ffha_pkg::GRANULE_SHIFT;

    typedef struct packed {
        logic          head;
        logic          alloc;
        logic [LW-1:0] len;
        logic [AW-1:0] prev;
    } t_word;

    // header memory and tag memory
    t_word       mem_hdr [HEAP_GRANULES];
    logic [31:0] mem_tag [HEAP_GRANULES];

    logic [1:0]               r_mode, n_mode;
    logic [ffha_pkg::NEED_W-1:0] r_need, n_need;
    logic [31:0]              r_tag, n_tag;
    logic [16:0]              r_handle, n_handle;
    logic [AW-1:0]            r_g, n_g;
    t_word                    r_gw, n_gw;
    t_word                    r_rd;
    logic [31:0]              r_rtag;
    logic [AW-1:0]            r_lx, n_lx;
    logic [LW-1:0]            r_ll, n_ll;
    logic [AW-1:0]            r_t, n_t;
    logic [AW-1:0]            r_cnt, n_cnt;
    logic [LW-1:0]            r_hg, n_hg;
    logic [LW-1:0]            r_ugran, n_ugran;
    logic [LW-1:0]            r_ublk, n_ublk;
    logic [16:0]              r_nh, n_nh;
    logic [1:0]               r_status, n_status;
    logic [16:0]              r_pay, n_pay;
    logic                     r_strobe, n_strobe;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_word         mem_wd;
    logic          tag_we;
    logic [AW-1:0] rd_addr;

    logic [AW-1:0] g_adv, fwd_n, link_t, dec_g;
    logic [31:0]   link_s, need_sum;
    logic [QW-1:0] q;
    t_word         init_w;

    // derived addresses
    always_comb begin
        g_adv    = AW'(32'(r_g) + 32'(r_rd.len));
        fwd_n    = AW'(32'(r_g) + 32'(r_gw.len));
        link_s   = 32'(r_lx) + 32'(r_ll);
        link_t   = (link_s >= 32'(r_hg)) ? '0 : AW'(link_s);
        q        = r_handle[16:ffha_pkg::GRANULE_SHIFT];
        dec_g    = AW'(32'(q) - 32'd1);
        need_sum = 32'(i_req.request_bytes) + 32'(ffha_pkg::GRANULE_BYTES - 1);
        init_w   = '{head: 1'b1, alloc: 1'b0, len: r_hg, prev: '0};
    end

    // status toward the controller
    always_comb begin
        o_stat.rd_len_zero = (r_rd.len == '0);
        o_stat.fit         = !r_rd.alloc && (32'(r_rd.len) >= 32'(r_need));
        o_stat.tag_hit     = r_rd.alloc && (r_rtag == r_tag);
        o_stat.adv_end     = (32'(r_g) + 32'(r_rd.len)) >= 32'(r_hg);
        o_stat.can_split   = (32'(r_gw.len) - 32'(r_need)) >= 32'd2;
        o_stat.back_ok     = (r_g != '0) && (r_gw.prev < r_g);
        o_stat.rd_alloc    = r_rd.alloc;
        o_stat.fwd_in      = (32'(r_g) + 32'(r_gw.len)) < 32'(r_hg);
        o_stat.clr_done    = (r_cnt == AW'(HEAP_GRANULES - 1));
        o_stat.dec_null    = (r_handle == '0);
        o_stat.dec_ok      = (r_handle[ffha_pkg::GRANULE_SHIFT-1:0] == '0) && (q != '0)
                             && ((32'(q) - 32'd1) < 32'(r_hg));
        o_stat.rd_owned    = r_rd.head && r_rd.alloc;
        o_stat.mode        = r_mode;
    end

    // execute the current operation
    always_comb begin
        n_mode = r_mode;   n_need = r_need;   n_tag = r_tag;   n_handle = r_handle;
        n_g = r_g;         n_gw = r_gw;       n_lx = r_lx;     n_ll = r_ll;
        n_t = r_t;         n_cnt = r_cnt;     n_hg = r_hg;
        n_ugran = r_ugran; n_ublk = r_ublk;
        n_nh = r_nh;       n_status = r_status; n_pay = r_pay;
        n_strobe = 1'b0;
        mem_we = 1'b0;     mem_wa = r_g;      mem_wd = r_gw;
        tag_we = 1'b0;     rd_addr = r_g;
        case (i_cmd.op)
            ffha_pkg::OP_LATCH: begin
                n_mode   = i_req.mode;
                n_need   = ffha_pkg::NEED_W'(need_sum >> ffha_pkg::GRANULE_SHIFT)
                           + ffha_pkg::NEED_W'(1);
                n_tag    = i_req.tag;
                n_handle = i_req.handle;
                n_g      = '0;
                n_nh     = '0;
                n_status = ffha_pkg::ST_OK;
                n_pay    = '0;
            end
            ffha_pkg::OP_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_cnt;
                mem_wd = (r_cnt == '0) ? init_w : '0;
                n_cnt  = r_cnt + AW'(1);
            end
            ffha_pkg::OP_RD_G: begin
                rd_addr = r_g;
            end
            ffha_pkg::OP_ADV: begin
                rd_addr = g_adv;
                n_g     = g_adv;
            end
            ffha_pkg::OP_LOAD: begin
                n_gw = r_rd;
            end
            ffha_pkg::OP_SPLIT: begin
                mem_we     = 1'b1;
                mem_wa     = AW'(32'(r_g) + 32'(r_need));
                mem_wd     = '{head: 1'b1, alloc: 1'b0,
                               len: LW'(32'(r_gw.len) - 32'(r_need)), prev: r_g};
                n_lx       = AW'(32'(r_g) + 32'(r_need));
                n_ll       = LW'(32'(r_gw.len) - 32'(r_need));
                n_gw.len   = LW'(r_need);
            end
            ffha_pkg::OP_AWG: begin
                mem_we  = 1'b1;
                mem_wa  = r_g;
                mem_wd  = '{head: 1'b1, alloc: 1'b1, len: r_gw.len, prev: r_gw.prev};
                tag_we  = 1'b1;
                n_ugran = r_ugran + r_gw.len;
                n_ublk  = r_ublk + LW'(1);
                n_nh    = 17'((32'(r_g) + 32'd1) << ffha_pkg::GRANULE_SHIFT);
            end
            ffha_pkg::OP_LRD: begin
                rd_addr = link_t;
                n_t     = link_t;
            end
            ffha_pkg::OP_LWR: begin
                mem_we      = 1'b1;
                mem_wa      = r_t;
                mem_wd      = r_rd;
                mem_wd.prev = r_lx;
                if (r_t == r_g) begin
                    n_gw.prev = r_lx;
                end
            end
            ffha_pkg::OP_DRD: begin
                rd_addr = dec_g;
                n_g     = dec_g;
            end
            ffha_pkg::OP_DBAD: begin
                n_status = (r_mode == ffha_pkg::MODE_FREE) ? ffha_pkg::ST_BAD : ffha_pkg::ST_OK;
            end
            ffha_pkg::OP_QUERY: begin
                n_pay = 17'((32'(r_rd.len) - 32'd1) << ffha_pkg::GRANULE_SHIFT);
            end
            ffha_pkg::OP_FAIL: begin
                n_status = ffha_pkg::ST_OOM;
            end
            ffha_pkg::OP_RSTART: begin
                n_ugran      = r_ugran - r_gw.len;
                n_ublk       = r_ublk - LW'(1);
                n_gw.alloc   = 1'b0;
                mem_we       = 1'b1;
                mem_wa       = r_g;
                mem_wd       = r_gw;
                mem_wd.alloc = 1'b0;
                rd_addr      = r_gw.prev;
            end
            ffha_pkg::OP_BMERGE: begin
                mem_we = 1'b1;
                mem_wa = r_g;
                mem_wd = '{head: 1'b0, alloc: 1'b0, len: r_gw.len, prev: r_gw.prev};
                n_gw   = '{head: 1'b1, alloc: 1'b0, len: r_rd.len + r_gw.len,
                           prev: r_rd.prev};
                n_g    = r_gw.prev;
            end
            ffha_pkg::OP_RWG: begin
                mem_we = 1'b1;
                mem_wa = r_g;
                mem_wd = r_gw;
                n_lx   = r_g;
                n_ll   = r_gw.len;
            end
            ffha_pkg::OP_FRD: begin
                rd_addr = fwd_n;
                n_t     = fwd_n;
            end
            ffha_pkg::OP_FMERGE: begin
                mem_we      = 1'b1;
                mem_wa      = r_t;
                mem_wd      = r_rd;
                mem_wd.head = 1'b0;
                n_gw.len    = r_gw.len + r_rd.len;
            end
            ffha_pkg::OP_TADV: begin
                rd_addr = fwd_n;
                n_g     = fwd_n;
            end
            ffha_pkg::OP_DONE: begin
                n_strobe = 1'b1;
            end
            default: begin
            end
        endcase
        // heap size write restarts the heap
        if (i_cfg_we) begin
            if (i_cfg_wdata < ffha_pkg::CFG_W'(2)) begin
                n_hg = LW'(2);
            end else if (32'(i_cfg_wdata) > 32'(HEAP_GRANULES)) begin
                n_hg = LW'(HEAP_GRANULES);
            end else begin
                n_hg = LW'(i_cfg_wdata);
            end
            n_cnt   = '0;
            n_ugran = '0;
            n_ublk  = '0;
        end
    end

    // memories with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_hdr[mem_wa] <= mem_wd;
        end
        if (tag_we) begin
            mem_tag[r_g] <= r_tag;
        end
        r_rd   <= mem_hdr[rd_addr];
        r_rtag <= mem_tag[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_hg     <= LW'(HEAP_GRANULES);
            r_cnt    <= '0;
            r_ugran  <= '0;
            r_ublk   <= '0;
        end else begin
            r_strobe <= n_strobe;
            r_hg     <= n_hg;
            r_cnt    <= n_cnt;
            r_ugran  <= n_ugran;
            r_ublk   <= n_ublk;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_need   <= n_need;
        r_tag    <= n_tag;
        r_handle <= n_handle;
        r_g      <= n_g;
        r_gw     <= n_gw;
        r_lx     <= n_lx;
        r_ll     <= n_ll;
        r_t      <= n_t;
        r_nh     <= n_nh;
        r_status <= n_status;
        r_pay    <= n_pay;
    end

    // result word
    always_comb begin
        o_res.new_handle    = r_nh;
        o_res.status        = r_status;
        o_res.payload_bytes = r_pay;
        o_res.used_bytes    = 18'(32'(r_ugran) << ffha_pkg::GRANULE_SHIFT);
        o_res.used_blocks   = 13'(r_ublk);
        o_done              = r_strobe;
    end

endmodule
`default_nettype wire

@@ hw/rtl/ffha_ctrl.sv @@
// Sequencer of the heap allocator: walks, splits, merges and the clearing pass.
// Depends on ffha_pkg; commands ffha_dpath through t_cmd.
`default_nettype none
module ffha_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    input  wire              i_cfg_we,
    input  ffha_pkg::t_stat  i_stat,
    output ffha_pkg::t_cmd   o_cmd,
    output logic             busy
);
    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_DISP    = 5'd2;
    localparam logic [4:0] S_A_CHK   = 5'd3;
    localparam logic [4:0] S_A_FOUND = 5'd4;
    localparam logic [4:0] S_A_WGS   = 5'd5;
    localparam logic [4:0] S_LINK_RD = 5'd6;
    localparam logic [4:0] S_LINK_WR = 5'd7;
    localparam logic [4:0] S_T_CHK   = 5'd8;
    localparam logic [4:0] S_T_NEXT  = 5'd9;
    localparam logic [4:0] S_D_CHK   = 5'd10;
    localparam logic [4:0] S_R_START = 5'd11;
    localparam logic [4:0] S_R_BCHK  = 5'd12;
    localparam logic [4:0] S_R_BWR   = 5'd13;
    localparam logic [4:0] S_R_FRD   = 5'd14;
    localparam logic [4:0] S_R_FCHK  = 5'd15;
    localparam logic [4:0] S_R_FWG   = 5'd16;
    localparam logic [4:0] S_R_END   = 5'd17;
    localparam logic [4:0] S_DONE    = 5'd18;

    localparam logic [1:0] RET_DONE = 2'd0;
    localparam logic [1:0] RET_FWD  = 2'd1;
    localparam logic [1:0] RET_REL  = 2'd2;

    logic [4:0] r_state, n_state;
    logic [1:0] r_ret, n_ret;

    // next state and command
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        o_cmd.op = ffha_pkg::OP_NOP;
        case (r_state)
            S_CLR: begin
                o_cmd.op = ffha_pkg::OP_CLR;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = ffha_pkg::OP_LATCH;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.mode == ffha_pkg::MODE_ALLOC) begin
                    o_cmd.op = ffha_pkg::OP_RD_G;
                    n_state  = S_A_CHK;
                end else if (i_stat.mode == ffha_pkg::MODE_FTAG) begin
                    o_cmd.op = ffha_pkg::OP_RD_G;
                    n_state  = S_T_CHK;
                end else if (i_stat.dec_null) begin
                    n_state = S_DONE;
                end else if (!i_stat.dec_ok) begin
                    o_cmd.op = ffha_pkg::OP_DBAD;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = ffha_pkg::OP_DRD;
                    n_state  = S_D_CHK;
                end
            end
            S_D_CHK: begin
                if (!i_stat.rd_owned) begin
                    o_cmd.op = ffha_pkg::OP_DBAD;
                    n_state  = S_DONE;
                end else if (i_stat.mode == ffha_pkg::MODE_QUERY) begin
                    o_cmd.op = ffha_pkg::OP_QUERY;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = ffha_pkg::OP_LOAD;
                    n_state  = S_R_START;
                end
            end
            // first-fit walk, one header a cycle
            S_A_CHK: begin
                if (i_stat.rd_len_zero) begin
                    o_cmd.op = ffha_pkg::OP_FAIL;
                    n_state  = S_DONE;
                end else if (i_stat.fit) begin
                    o_cmd.op = ffha_pkg::OP_LOAD;
                    n_state  = S_A_FOUND;
                end else if (i_stat.adv_end) begin
                    o_cmd.op = ffha_pkg::OP_FAIL;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = ffha_pkg::OP_ADV;
                end
            end
            S_A_FOUND: begin
                if (i_stat.can_split) begin
                    o_cmd.op = ffha_pkg::OP_SPLIT;
                    n_state  = S_A_WGS;
                end else begin
                    o_cmd.op = ffha_pkg::OP_AWG;
                    n_state  = S_DONE;
                end
            end
            S_A_WGS: begin
                o_cmd.op = ffha_pkg::OP_AWG;
                n_ret    = RET_DONE;
                n_state  = S_LINK_RD;
            end
            // point the following block back at the current one
            S_LINK_RD: begin
                o_cmd.op = ffha_pkg::OP_LRD;
                n_state  = S_LINK_WR;
            end
            S_LINK_WR: begin
                o_cmd.op = ffha_pkg::OP_LWR;
                case (r_ret)
                    RET_FWD: n_state = S_R_FRD;
                    RET_REL: n_state = S_R_END;
                    default: n_state = S_DONE;
                endcase
            end
            // free-by-tag walk
            S_T_CHK: begin
                if (i_stat.rd_len_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.tag_hit) begin
                    o_cmd.op = ffha_pkg::OP_LOAD;
                    n_state  = S_R_START;
                end else if (i_stat.adv_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = ffha_pkg::OP_ADV;
                end
            end
            S_T_NEXT: begin
                if (!i_stat.fwd_in) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = ffha_pkg::OP_TADV;
                    n_state  = S_T_CHK;
                end
            end
            // release with merge backward, then forward
            S_R_START: begin
                o_cmd.op = ffha_pkg::OP_RSTART;
                n_state  = i_stat.back_ok ? S_R_BCHK : S_R_FRD;
            end
            S_R_BCHK: begin
                if (!i_stat.rd_alloc) begin
                    o_cmd.op = ffha_pkg::OP_BMERGE;
                    n_state  = S_R_BWR;
                end else begin
                    n_state = S_R_FRD;
                end
            end
            S_R_BWR: begin
                o_cmd.op = ffha_pkg::OP_RWG;
                n_ret    = RET_FWD;
                n_state  = S_LINK_RD;
            end
            S_R_FRD: begin
                if (i_stat.fwd_in) begin
                    o_cmd.op = ffha_pkg::OP_FRD;
                    n_state  = S_R_FCHK;
                end else begin
                    n_state = S_R_END;
                end
            end
            S_R_FCHK: begin
                if (!i_stat.rd_alloc) begin
                    o_cmd.op = ffha_pkg::OP_FMERGE;
                    n_state  = S_R_FWG;
                end else begin
                    n_state = S_R_END;
                end
            end
            S_R_FWG: begin
                o_cmd.op = ffha_pkg::OP_RWG;
                n_ret    = RET_REL;
                n_state  = S_LINK_RD;
            end
            S_R_END: begin
                n_state = (i_stat.mode == ffha_pkg::MODE_FTAG) ? S_T_NEXT : S_DONE;
            end
            S_DONE: begin
                o_cmd.op = ffha_pkg::OP_DONE;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // heap size write forces a new clearing pass
        if (i_cfg_we) n_state = S_CLR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret   <= RET_DONE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

@@ tb/ffha_checker.sv @@
// Scoreboard for the first-fit heap allocator: mirrors the heap state, predicts every result word.
// Depends on ffha_pkg; instantiated by tb_first_fit_heap_allocator_unit beside the block.
`default_nettype none
module ffha_checker #(
    parameter int HEAP_GRANULES = 4096
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       start,
    input  wire                       busy,
    input  ffha_pkg::t_req            i_req,
    input  wire                       o_done,
    input  ffha_pkg::t_res            o_res,
    input  wire                       i_cfg_we,
    input  wire [ffha_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                        o_fail_count,
    output int                        o_pending
);
    import ffha_pkg::*;

    // mirrored heap state
    int unsigned heap_size;
    bit          is_head  [HEAP_GRANULES];
    bit          is_alloc [HEAP_GRANULES];
    int unsigned blk_len  [HEAP_GRANULES];
    int unsigned back_link[HEAP_GRANULES];
    logic [31:0] owner    [HEAP_GRANULES];
    int unsigned used_gran;
    int unsigned used_cnt;

    t_res expected_words[$];

    // rebuild the heap as one free block
    function automatic void clear_heap();
        for (int i = 0; i < HEAP_GRANULES; i++) begin
            is_head[i]   = 0;
            is_alloc[i]  = 0;
            blk_len[i]   = 0;
            back_link[i] = 0;
        end
        is_head[0] = 1;
        blk_len[0] = heap_size;
        used_gran  = 0;
        used_cnt   = 0;
    endfunction

    function automatic int unsigned follow(int unsigned g);
        int unsigned n;
        n = g + blk_len[g];
        return (n >= heap_size) ? 0 : n;
    endfunction

    // free block g, merge with free neighbors, return merged head
    function automatic int unsigned free_block(int unsigned g_in);
        int unsigned g, p, n;
        g = g_in;
        used_gran -= blk_len[g];
        used_cnt  -= 1;
        is_alloc[g] = 0;
        p = back_link[g];
        if (g != 0 && p < g && !is_alloc[p]) begin
            blk_len[p] += blk_len[g];
            is_head[g] = 0;
            back_link[follow(p)] = p;
            g = p;
        end
        n = g + blk_len[g];
        if (n < heap_size && !is_alloc[n]) begin
            blk_len[g] += blk_len[n];
            is_head[n] = 0;
            back_link[follow(g)] = g;
        end
        return g;
    endfunction

    // map a handle to an allocated head granule, or -1
    function automatic int handle_head(logic [16:0] h);
        int unsigned q;
        if (h[4:0] != 0) return -1;
        q = h >> GRANULE_SHIFT;
        if (q == 0 || q - 1 >= heap_size) return -1;
        q -= 1;
        if (!is_head[q] || !is_alloc[q]) return -1;
        return int'(q);
    endfunction

    // apply one request word, return the result word it causes
    function automatic t_res predict_word(t_req r);
        t_res        w;
        int unsigned need, g, len, nb;
        int          hd;
        bit          found;
        w = '0;
        case (r.mode)
            MODE_ALLOC: begin
                need  = (int'(r.request_bytes) + GRANULE_BYTES - 1) / GRANULE_BYTES + 1;
                found = 0;
                g     = 0;
                while (g < heap_size && blk_len[g] != 0) begin
                    if (!is_alloc[g] && blk_len[g] >= need) begin
                        found = 1;
                        break;
                    end
                    g += blk_len[g];
                end
                if (found) begin
                    len = blk_len[g];
                    if (len - need >= 2) begin
                        nb = g + need;
                        is_head[nb]   = 1;
                        is_alloc[nb]  = 0;
                        blk_len[nb]   = len - need;
                        back_link[nb] = g;
                        back_link[follow(nb)] = nb;
                        blk_len[g] = need;
                    end
                    is_alloc[g] = 1;
                    owner[g]    = r.tag;
                    used_gran  += blk_len[g];
                    used_cnt   += 1;
                    w.new_handle = 17'((g + 1) * GRANULE_BYTES);
                end else begin
                    w.status = ST_OOM;
                end
            end
            MODE_FREE: begin
                if (r.handle != 0) begin
                    hd = handle_head(r.handle);
                    if (hd >= 0) void'(free_block(hd));
                    else w.status = ST_BAD;
                end
            end
            MODE_FTAG: begin
                g = 0;
                while (g < heap_size && blk_len[g] != 0) begin
                    if (is_alloc[g] && owner[g] == r.tag) g = free_block(g);
                    g += blk_len[g];
                end
            end
            default: begin
                if (r.handle != 0) begin
                    hd = handle_head(r.handle);
                    if (hd >= 0) w.payload_bytes = 17'((blk_len[hd] - 1) * GRANULE_BYTES);
                end
            end
        endcase
        w.used_bytes  = 18'(used_gran * GRANULE_BYTES);
        w.used_blocks = 13'(used_cnt);
        return w;
    endfunction

    assign o_pending = expected_words.size();

    // retire result words first, then record newly accepted requests
    always @(posedge i_clk) begin
        t_res        exp_w;
        int unsigned v;
        if (!i_rst_n) begin
            heap_size = HEAP_GRANULES;
            clear_heap();
            expected_words.delete();
            o_fail_count <= 0;
        end else begin
            if (o_done) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no request outstanding");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (o_res.new_handle !== exp_w.new_handle ||
                        o_res.status !== exp_w.status ||
                        o_res.payload_bytes !== exp_w.payload_bytes ||
                        o_res.used_bytes !== exp_w.used_bytes ||
                        o_res.used_blocks !== exp_w.used_blocks)
                        o_fail_count <= o_fail_count + 1;
                    if (o_res.new_handle !== exp_w.new_handle)
                        $error("new_handle expected %0d got %0d",
                               exp_w.new_handle, o_res.new_handle);
                    if (o_res.status !== exp_w.status)
                        $error("status expected %0d got %0d", exp_w.status, o_res.status);
                    if (o_res.payload_bytes !== exp_w.payload_bytes)
                        $error("payload_bytes expected %0d got %0d",
                               exp_w.payload_bytes, o_res.payload_bytes);
                    if (o_res.used_bytes !== exp_w.used_bytes)
                        $error("used_bytes expected %0d got %0d",
                               exp_w.used_bytes, o_res.used_bytes);
                    if (o_res.used_blocks !== exp_w.used_blocks)
                        $error("used_blocks expected %0d got %0d",
                               exp_w.used_blocks, o_res.used_blocks);
                end
            end
            if (start && !busy)
                expected_words.push_back(predict_word(i_req));
            if (i_cfg_we) begin
                v = i_cfg_wdata;
                if (v < 2) v = 2;
                if (v > HEAP_GRANULES) v = HEAP_GRANULES;
                heap_size = v;
                clear_heap();
            end
        end
    end
endmodule
`default_nettype wire

@@ tb/tb_first_fit_heap_allocator_unit.sv @@
// Testbench top for first_fit_heap_allocator_unit: drives request words and heap sizes.
// Depends on ffha_pkg, the block, and ffha_checker which predicts and compares results.
`default_nettype none
module tb_first_fit_heap_allocator_unit;
    import ffha_pkg::*;

    localparam int HEAP_G      = 4096;
    localparam int CYCLE_LIMIT = 8000000;

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             start = 0;
    logic             busy;
    t_req             i_req = '0;
    logic             o_done;
    t_res             o_res;
    logic             i_cfg_we = 0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    int               fail_count;
    int               pending;
    int               cycles = 0;

    logic [16:0] live_handles[$];
    logic [31:0] tag_pool[4];
    int unsigned cur_heap = HEAP_G;

    always #4 i_clk = ~i_clk;

    first_fit_heap_allocator_unit #(.HEAP_GRANULES(HEAP_G)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_done(o_done), .o_res(o_res), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    ffha_checker #(.HEAP_GRANULES(HEAP_G)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_done(o_done), .o_res(o_res), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // hold a window of handles handed out so frees and queries hit real blocks
    always @(posedge i_clk) begin
        if (o_done && o_res.new_handle != 0) begin
            live_handles.push_back(o_res.new_handle);
            if (live_handles.size() > 64) void'(live_handles.pop_front());
        end
    end

    // abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_first_fit_heap_allocator_unit failed");
            $finish;
        end
    end

    // present one request word after a random gap and hold it until accepted
    task automatic send_word(t_req r);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1;
        i_req <= r;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic send_fields(logic [1:0] m, logic [19:0] rb, logic [31:0] tg, logic [16:0] h);
        t_req r;
        r.mode = m;
        r.request_bytes = rb;
        r.tag = tg;
        r.handle = h;
        send_word(r);
    endtask

    // drain outstanding results, then write a new heap size while idle
    task automatic set_heap(logic [CFG_W-1:0] v);
        start <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        live_handles.delete();
        cur_heap = (v < 2) ? 2 : ((v > HEAP_G) ? HEAP_G : v);
    endtask

    function automatic logic [16:0] pick_handle();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70 && live_handles.size() != 0)
            return live_handles[$urandom_range(0, live_handles.size() - 1)];
        if (sel < 85) return 17'($urandom_range(0, cur_heap + 1) * GRANULE_BYTES);
        return 17'($urandom);
    endfunction

    task automatic random_word();
        t_req r;
        int   sel;
        r.tag = ($urandom_range(0, 99) < 85) ? tag_pool[$urandom_range(0, 3)] : $urandom;
        r.handle = pick_handle();
        r.request_bytes = 20'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            r.mode = MODE_ALLOC;
            sel = $urandom_range(0, 99);
            if (sel < 65) r.request_bytes = 20'($urandom_range(0, 160));
            else if (sel < 85) r.request_bytes = 20'($urandom_range(0, cur_heap * 32));
            else if (sel < 95) r.request_bytes = 20'((cur_heap - 1) * 32 - $urandom_range(0, 1));
        end else if (sel < 70) begin
            r.mode = MODE_FREE;
        end else if (sel < 80) begin
            r.mode = MODE_FTAG;
        end else begin
            r.mode = MODE_QUERY;
        end
        send_word(r);
    endtask

    initial begin
        logic [CFG_W-1:0] sizes[9];
        sizes = '{13'd2, 13'd3, 13'd0, 13'd16, 13'd1, 13'd64, 13'd8191, 13'd200, 13'd4096};
        for (int i = 0; i < 4; i++) tag_pool[i] = $urandom;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: field extremes and each corner case
        send_fields(MODE_ALLOC, 20'd0, tag_pool[0], 17'd0);
        send_fields(MODE_ALLOC, 20'd1, tag_pool[1], 17'h1FFFF);
        send_fields(MODE_ALLOC, 20'd32, 32'hFFFF_FFFF, 17'd0);
        send_fields(MODE_ALLOC, 20'd33, 32'h0, 17'd0);
        send_fields(MODE_ALLOC, 20'hFFFFF, tag_pool[0], 17'd0);
        send_fields(MODE_QUERY, 20'hFFFFF, 32'hFFFF_FFFF, 17'd32);
        send_fields(MODE_QUERY, 20'd0, 32'h0, 17'd0);
        send_fields(MODE_FREE, 20'd0, 32'h0, 17'd0);
        send_fields(MODE_FREE, 20'd0, 32'h0, 17'h1FFFF);
        send_fields(MODE_FREE, 20'd0, 32'h0, 17'd33);
        send_fields(MODE_FREE, 20'd0, 32'h0, 17'd131040);
        send_fields(MODE_QUERY, 20'd0, 32'h0, 17'd131040);
        send_fields(MODE_FREE, 20'd0, 32'h0, 17'd64);
        send_fields(MODE_FREE, 20'd0, 32'h0, 17'd32);
        send_fields(MODE_FREE, 20'd0, 32'h0, 17'd32);
        send_fields(MODE_FTAG, 20'd0, 32'h1234_5678, 17'd0);
        send_fields(MODE_FTAG, 20'd0, tag_pool[1], 17'd0);
        send_fields(MODE_ALLOC, 20'd131008, tag_pool[2], 17'd0);
        send_fields(MODE_ALLOC, 20'd131009, tag_pool[2], 17'd0);
        send_fields(MODE_FTAG, 20'hFFFFF, 32'hFFFF_FFFF, 17'h1FFFF);
        send_fields(MODE_FTAG, 20'd0, tag_pool[2], 17'd0);

        // random traffic at the reset heap size, then across heap sizes
        for (int k = 0; k < 90; k++) random_word();
        foreach (sizes[s]) begin
            set_heap(sizes[s]);
            for (int k = 0; k < 90; k++) random_word();
        end

        start <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_first_fit_heap_allocator_unit passed");
        end else begin
            $display("tb_first_fit_heap_allocator_unit failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
